// ----- rtl/core/srvm_pkg.sv -----
// ----------------------------------------------------------------------------
// srvm_pkg
// shared opcodes, register indexes and types of the six-register vm core
// ----------------------------------------------------------------------------
`default_nettype none

package srvm_pkg;

   localparam int unsigned WORD_W = 32;

   // opcodes of one instruction
   typedef enum logic [3:0] {
      ADDR = 4'd0,
      ADDI = 4'd1,
      MULR = 4'd2,
      MULI = 4'd3,
      BANR = 4'd4,
      BANI = 4'd5,
      BORR = 4'd6,
      BORI = 4'd7,
      SETR = 4'd8,
      SETI = 4'd9,
      GTIR = 4'd10,
      GTRI = 4'd11,
      GTRR = 4'd12,
      EQIR = 4'd13,
      EQRI = 4'd14,
      EQRR = 4'd15
   } mode_type;

   // configuration register indexes
   localparam logic [1:0] CSR_POINTER_BOUND  = 2'd0;
   localparam logic [1:0] CSR_BOUND_REGISTER = 2'd1;
   localparam logic [1:0] CSR_PROGRAM_LENGTH = 2'd2;

   typedef struct packed {
      logic                error;
      logic [WORD_W-1:0]   result;
   } alu_out_type;

endpackage

`default_nettype wire

// ----- rtl/core/srvm_regfile.sv -----
// ----------------------------------------------------------------------------
// srvm_regfile
// register file memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module srvm_regfile #(
   parameter int unsigned NUM_REGISTERS = 6
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   rd_en,
   input  wire logic [$clog2(NUM_REGISTERS)-1:0]       rd_idx_a,
   input  wire logic [$clog2(NUM_REGISTERS)-1:0]       rd_idx_b,
   input  wire logic                                   wr_en,
   input  wire logic [$clog2(NUM_REGISTERS)-1:0]       wr_idx,
   input  wire logic [srvm_pkg::WORD_W-1:0]            wr_data,
   output logic      [srvm_pkg::WORD_W-1:0]            rd_data_a,
   output logic      [srvm_pkg::WORD_W-1:0]            rd_data_b
);

   logic [srvm_pkg::WORD_W-1:0] mem [NUM_REGISTERS];
   logic [NUM_REGISTERS-1:0]    valid_ff;
   logic [srvm_pkg::WORD_W-1:0] mem_a_ff;
   logic [srvm_pkg::WORD_W-1:0] mem_b_ff;
   logic                        vld_a_ff;
   logic                        vld_b_ff;
   logic                        fwd_a_ff;
   logic                        fwd_b_ff;
   logic [srvm_pkg::WORD_W-1:0] fwd_data_ff;

   // memory array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         mem_a_ff <= mem[rd_idx_a];
         mem_b_ff <= mem[rd_idx_b];
      end
   end

   // per-entry written flags, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // bypass for a write landing on the same edge as the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         vld_a_ff    <= valid_ff[rd_idx_a];
         vld_b_ff    <= valid_ff[rd_idx_b];
         fwd_a_ff    <= wr_en && (wr_idx == rd_idx_a);
         fwd_b_ff    <= wr_en && (wr_idx == rd_idx_b);
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      rd_data_a = fwd_a_ff ? fwd_data_ff : (vld_a_ff ? mem_a_ff : '0);
      rd_data_b = fwd_b_ff ? fwd_data_ff : (vld_b_ff ? mem_b_ff : '0);
   end

endmodule

`default_nettype wire

// ----- rtl/core/srvm_alu.sv -----
// ----------------------------------------------------------------------------
// srvm_alu
// operand selection, index checks and the opcode datapath
// ----------------------------------------------------------------------------
`default_nettype none

module srvm_alu #(
   parameter int unsigned NUM_REGISTERS = 6
) (
   input  wire srvm_pkg::mode_type                 mode,
   input  wire logic [srvm_pkg::WORD_W-1:0]        operand_a,
   input  wire logic [srvm_pkg::WORD_W-1:0]        operand_b,
   input  wire logic [2:0]                         dest_index,
   input  wire logic                               pointer_bound,
   input  wire logic [2:0]                         bound_register,
   input  wire logic [srvm_pkg::WORD_W-1:0]        reg_a,
   input  wire logic [srvm_pkg::WORD_W-1:0]        reg_b,
   output srvm_pkg::alu_out_type                   alu_out
);

   localparam logic [srvm_pkg::WORD_W-1:0] NREG = srvm_pkg::WORD_W'(NUM_REGISTERS);

   logic                        a_reg;
   logic                        b_reg;
   logic [srvm_pkg::WORD_W-1:0] va;
   logic [srvm_pkg::WORD_W-1:0] vb;
   logic [srvm_pkg::WORD_W-1:0] res;

   always_comb begin
      a_reg = !(mode == srvm_pkg::SETI || mode == srvm_pkg::GTIR ||
                mode == srvm_pkg::EQIR);
      b_reg = (mode == srvm_pkg::ADDR || mode == srvm_pkg::MULR ||
               mode == srvm_pkg::BANR || mode == srvm_pkg::BORR ||
               mode == srvm_pkg::GTIR || mode == srvm_pkg::GTRR ||
               mode == srvm_pkg::EQIR || mode == srvm_pkg::EQRR);

      va = a_reg ? reg_a : operand_a;
      vb = b_reg ? reg_b : operand_b;

      case (mode)
         srvm_pkg::ADDR, srvm_pkg::ADDI: res = va + vb;
         srvm_pkg::MULR, srvm_pkg::MULI: res = va * vb;
         srvm_pkg::BANR, srvm_pkg::BANI: res = va & vb;
         srvm_pkg::BORR, srvm_pkg::BORI: res = va | vb;
         srvm_pkg::SETR, srvm_pkg::SETI: res = va;
         srvm_pkg::GTIR, srvm_pkg::GTRI, srvm_pkg::GTRR:
            res = srvm_pkg::WORD_W'($signed(va) > $signed(vb));
         srvm_pkg::EQIR, srvm_pkg::EQRI, srvm_pkg::EQRR:
            res = srvm_pkg::WORD_W'(va == vb);
         default: res = '0;
      endcase

      alu_out.result = res;
      alu_out.error  = (a_reg && (operand_a >= NREG)) ||
                       (b_reg && (operand_b >= NREG)) ||
                       (srvm_pkg::WORD_W'(dest_index) >= NREG) ||
                       (pointer_bound && (srvm_pkg::WORD_W'(bound_register) >= NREG));
   end

endmodule

`default_nettype wire

// ----- rtl/core/six_register_vm_execute_core.sv -----
// ----------------------------------------------------------------------------
// six_register_vm_execute_core
// executes one fetched instruction per transaction on a small register file
// ----------------------------------------------------------------------------
// flow: an accepted request is held in the input register, executes into the result
// register and leaves from there; back-to-back at one instruction per cycle while
// responses are taken, with a single execute stage that writes the register file
// reset: synchronous, active high; registers, pointer and configuration read as
// zero after reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module six_register_vm_execute_core #(
   parameter int unsigned NUM_REGISTERS = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,

   // request: mode[3:0], operand_a[35:4], operand_b[67:36], dest_index[70:68]
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [71:0]   req_tdata,

   // response: next_pointer[31:0], written_value[63:32], register_zero[95:64],
   // halted[96], error[97]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [103:0]       rsp_tdata,

   // configuration writes
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_data
);

   localparam int unsigned IDX_W  = $clog2(NUM_REGISTERS);
   localparam int unsigned WORD_W = srvm_pkg::WORD_W;

   // configuration
   logic         pointer_bound_ff;
   logic [2:0]   bound_register_ff;
   logic [15:0]  program_length_ff;
   logic         csr_fire;

   // input register
   logic                 s1_valid_ff;
   srvm_pkg::mode_type   s1_mode_ff;
   logic [WORD_W-1:0]    s1_a_ff;
   logic [WORD_W-1:0]    s1_b_ff;
   logic [2:0]           s1_dest_ff;

   // architectural state beside the register file
   logic [WORD_W-1:0]    ip_ff;
   logic [WORD_W-1:0]    ip_in;
   logic [WORD_W-1:0]    r0_ff;
   logic [WORD_W-1:0]    r0_in;

   // pointer copy parked for the bound register, not yet in the memory
   logic                 sh_valid_ff;
   logic [IDX_W-1:0]     sh_idx_ff;
   logic [WORD_W-1:0]    sh_val_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [WORD_W-1:0]    rsp_np_ff;
   logic [WORD_W-1:0]    rsp_wv_ff;
   logic [WORD_W-1:0]    rsp_r0_ff;
   logic                 rsp_err_ff;
   logic                 rsp_halted;

   // handshake and datapath
   logic                 accept;
   logic                 exec_fire;
   logic                 commit;
   logic [IDX_W-1:0]     bound_idx;
   logic [IDX_W-1:0]     a_idx;
   logic [IDX_W-1:0]     b_idx;
   logic [IDX_W-1:0]     c_idx;
   logic [WORD_W-1:0]    raw_a;
   logic [WORD_W-1:0]    raw_b;
   logic [WORD_W-1:0]    eff_a;
   logic [WORD_W-1:0]    eff_b;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   logic [WORD_W-1:0]    wr_data;
   srvm_pkg::alu_out_type alu_out;

   // ------------------------------------------------------------------------
   // flow control: execute when the result register is free or draining
   // ------------------------------------------------------------------------
   always_comb begin
      exec_fire  = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !s1_valid_ff || exec_fire;
      accept     = req_tvalid && req_tready;
      csr_ready  = 1'b1;
      csr_fire   = csr_valid && csr_ready;
   end

   // ------------------------------------------------------------------------
   // configuration registers; indexes beyond the list are ignored
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_bound_ff  <= 1'b0;
         bound_register_ff <= '0;
         program_length_ff <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            srvm_pkg::CSR_POINTER_BOUND:  pointer_bound_ff  <= csr_data[0];
            srvm_pkg::CSR_BOUND_REGISTER: bound_register_ff <= csr_data[2:0];
            srvm_pkg::CSR_PROGRAM_LENGTH: program_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // input register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (exec_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff <= srvm_pkg::mode_type'(req_tdata[3:0]);
         s1_a_ff    <= req_tdata[35:4];
         s1_b_ff    <= req_tdata[67:36];
         s1_dest_ff <= req_tdata[70:68];
      end
   end

   // ------------------------------------------------------------------------
   // register file: read at accept, written by the execute stage or by the
   // flush of a parked pointer copy on a configuration write
   // ------------------------------------------------------------------------
   always_comb begin
      bound_idx = IDX_W'(bound_register_ff);
      a_idx     = s1_a_ff[IDX_W-1:0];
      b_idx     = s1_b_ff[IDX_W-1:0];
      c_idx     = IDX_W'(s1_dest_ff);
      commit    = csr_fire && sh_valid_ff;
      wr_en     = (exec_fire && !alu_out.error) || commit;
      wr_idx    = (exec_fire && !alu_out.error) ? c_idx : sh_idx_ff;
      wr_data   = (exec_fire && !alu_out.error) ? alu_out.result : sh_val_ff;
   end

   srvm_regfile #(
      .NUM_REGISTERS (NUM_REGISTERS)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_idx_a  (req_tdata[4 +: IDX_W]),
      .rd_idx_b  (req_tdata[36 +: IDX_W]),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .rd_data_a (raw_a),
      .rd_data_b (raw_b)
   );

   // overlay: with pointer binding on, the bound register holds the pointer at execute time,
   // a parked copy stands in for its memory entry
   always_comb begin
      if (pointer_bound_ff && (bound_idx == a_idx)) begin
         eff_a = ip_ff;
      end else if (sh_valid_ff && (sh_idx_ff == a_idx)) begin
         eff_a = sh_val_ff;
      end else begin
         eff_a = raw_a;
      end
      if (pointer_bound_ff && (bound_idx == b_idx)) begin
         eff_b = ip_ff;
      end else if (sh_valid_ff && (sh_idx_ff == b_idx)) begin
         eff_b = sh_val_ff;
      end else begin
         eff_b = raw_b;
      end
   end

   srvm_alu #(
      .NUM_REGISTERS (NUM_REGISTERS)
   ) u_alu (
      .mode           (s1_mode_ff),
      .operand_a      (s1_a_ff),
      .operand_b      (s1_b_ff),
      .dest_index     (s1_dest_ff),
      .pointer_bound  (pointer_bound_ff),
      .bound_register (bound_register_ff),
      .reg_a          (eff_a),
      .reg_b          (eff_b),
      .alu_out        (alu_out)
   );

   // ------------------------------------------------------------------------
   // pointer and register zero after the instruction
   // ------------------------------------------------------------------------
   always_comb begin
      if (pointer_bound_ff && (bound_idx == c_idx)) begin
         ip_in = alu_out.result + WORD_W'(1);
      end else begin
         ip_in = ip_ff + WORD_W'(1);
      end
      if (c_idx == '0) begin
         r0_in = alu_out.result;
      end else if (pointer_bound_ff && (bound_idx == '0)) begin
         r0_in = ip_ff;
      end else begin
         r0_in = r0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff       <= '0;
         r0_ff       <= '0;
         sh_valid_ff <= 1'b0;
      end else if (exec_fire && !alu_out.error) begin
         ip_ff       <= ip_in;
         r0_ff       <= r0_in;
         sh_valid_ff <= pointer_bound_ff && (bound_idx != c_idx);
      end else if (commit) begin
         sh_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire && !alu_out.error) begin
         sh_idx_ff <= bound_idx;
         sh_val_ff <= ip_ff;
      end
   end

   // ------------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_err_ff <= alu_out.error;
         if (alu_out.error) begin
            rsp_np_ff <= ip_ff;
            rsp_wv_ff <= '0;
            rsp_r0_ff <= r0_ff;
         end else begin
            rsp_np_ff <= ip_in;
            rsp_wv_ff <= alu_out.result;
            rsp_r0_ff <= r0_in;
         end
      end
   end

   // halt check on the held pointer; the user keeps program length put while a
   // response is pending, the block itself does not enforce it
   always_comb begin
      rsp_halted = rsp_np_ff[WORD_W-1] ||
                   (rsp_np_ff >= WORD_W'(program_length_ff));
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {6'b0, rsp_err_ff, rsp_halted, rsp_r0_ff, rsp_wv_ff, rsp_np_ff};
   end

endmodule

`default_nettype wire
